/* hdl/bat_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bat_pkg
// shared constants and a helper function for the advertising tracker classifier
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_TAG     = 3'd1;
    localparam logic [2:0] KIND_NEARBY  = 3'd2;
    localparam logic [2:0] KIND_PAIRING = 3'd3;
    localparam logic [2:0] KIND_STAG    = 3'd4;
    localparam logic [2:0] KIND_UUID    = 3'd5;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;

    localparam logic [7:0] AD_MFR_DATA   = 8'hFF;
    localparam logic [7:0] AD_UUID16_INC = 8'h02;
    localparam logic [7:0] AD_UUID16_ALL = 8'h03;

    localparam logic [15:0] CID_VENDOR_A = 16'h004C;
    localparam logic [15:0] CID_VENDOR_B = 16'h0075;

    localparam logic [7:0] SUB_TAG     = 8'h12;
    localparam logic [7:0] SUB_NEARBY  = 8'h10;
    localparam logic [7:0] SUB_PAIRING = 8'h07;

    localparam logic [15:0] UUID_TRACK_A = 16'hFEED;
    localparam logic [15:0] UUID_TRACK_B = 16'hFD84;

    localparam logic [7:0] HOLD_NONE    = 8'd0;
    localparam logic [7:0] HOLD_CID_OK  = 8'd1;
    localparam logic [7:0] HOLD_WANT_MD = 8'd2;

    localparam logic [7:0] BYTE_LIMIT = 8'hFF;

    localparam int OUT_TDATA_W = 16;

    function automatic logic is_known_model(input logic [7:0] m);
        logic hit;
        begin
            case (m)
                8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09,
                8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11,
                8'h13, 8'h14, 8'h19, 8'h1A: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/ble_adv_tracker_classifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ble_adv_tracker_classifier
// walks advertising ad structures byte by byte and reports tracker kind
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock cycle on the slave stream
// whenever the input is not stalled. Each byte passes an input register and
// then the structure-walk logic that updates the walk state; a byte marked
// tlast produces one result transaction, written to the output register when
// it leaves the input register. The output register is the only buffer for
// results, so the input stalls only when a last byte meets a result the
// sink has not yet taken. tuser marks the first byte of an advertisement.
module ble_adv_tracker_classifier
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // first
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [bat_pkg::OUT_TDATA_W-1:0] m_tdata
    // m_tdata: matched[0], kind[3:1], model[11:4], model_known[12], zero[15:13]
);
    import bat_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;
    logic       advance;

    // walk state
    logic [7:0] count_reg,   count_next;
    logic [1:0] phase_reg,   phase_next;
    logic [7:0] len_reg,     len_next;
    logic [7:0] type_reg,    type_next;
    logic [7:0] vidx_reg,    vidx_next;
    logic [7:0] hold_reg,    hold_next;
    logic [2:0] pkind_reg,   pkind_next;
    logic [7:0] pmodel_reg,  pmodel_next;
    logic [2:0] fkind_reg,   fkind_next;
    logic [7:0] fmodel_reg,  fmodel_next;
    logic       stopped_reg, stopped_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg,  out_data_next;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    always_comb
    begin
        logic [7:0]  c_count, c_len, c_type, c_vidx, c_hold, c_pmodel, c_fmodel;
        logic [1:0]  c_phase;
        logic [2:0]  c_pkind, c_fkind;
        logic        c_stopped;
        logic        end_struct;
        logic [7:0]  b;
        logic [15:0] pair;
        logic [2:0]  r_kind;
        logic [7:0]  r_model;
        logic        r_known;

        b          = in_byte_reg;
        pair       = {b, 8'd0};
        end_struct = 1'b0;
        r_kind     = KIND_NONE;
        r_model    = 8'd0;
        r_known    = 1'b0;

        if (in_first_reg)
        begin
            c_count   = 8'd0;
            c_phase   = PH_LEN;
            c_len     = 8'd0;
            c_type    = 8'd0;
            c_vidx    = 8'd0;
            c_hold    = HOLD_NONE;
            c_pkind   = KIND_NONE;
            c_pmodel  = 8'd0;
            c_fkind   = KIND_NONE;
            c_fmodel  = 8'd0;
            c_stopped = 1'b0;
        end
        else
        begin
            c_count   = count_reg;
            c_phase   = phase_reg;
            c_len     = len_reg;
            c_type    = type_reg;
            c_vidx    = vidx_reg;
            c_hold    = hold_reg;
            c_pkind   = pkind_reg;
            c_pmodel  = pmodel_reg;
            c_fkind   = fkind_reg;
            c_fmodel  = fmodel_reg;
            c_stopped = stopped_reg;
        end

        count_next   = c_count;
        phase_next   = c_phase;
        len_next     = c_len;
        type_next    = c_type;
        vidx_next    = c_vidx;
        hold_next    = c_hold;
        pkind_next   = c_pkind;
        pmodel_next  = c_pmodel;
        fkind_next   = c_fkind;
        fmodel_next  = c_fmodel;
        stopped_next = c_stopped;

        if (c_count != BYTE_LIMIT)
        begin
            count_next = c_count + 8'd1;
            if (!c_stopped)
            begin
                case (c_phase)
                    PH_LEN:
                    begin
                        if (b == 8'd0)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            len_next   = b;
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next   = b;
                        vidx_next   = 8'd0;
                        hold_next   = HOLD_NONE;
                        pkind_next  = KIND_NONE;
                        pmodel_next = 8'd0;
                        if (c_len == 8'd1)
                        begin
                            end_struct = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_VAL;
                        end
                    end
                    default:
                    begin
                        pair = {b, c_hold};
                        if (c_type == AD_MFR_DATA)
                        begin
                            if (c_vidx == 8'd0)
                            begin
                                hold_next = b;
                            end
                            else if (c_vidx == 8'd1)
                            begin
                                hold_next = HOLD_NONE;
                                if (pair == CID_VENDOR_A)
                                begin
                                    hold_next = HOLD_CID_OK;
                                end
                                else if (pair == CID_VENDOR_B)
                                begin
                                    pkind_next = KIND_STAG;
                                end
                            end
                            else if (c_vidx == 8'd2)
                            begin
                                if (c_hold == HOLD_CID_OK)
                                begin
                                    hold_next = HOLD_NONE;
                                    if (b == SUB_TAG)
                                    begin
                                        pkind_next = KIND_TAG;
                                    end
                                    else if (b == SUB_NEARBY)
                                    begin
                                        pkind_next = KIND_NEARBY;
                                    end
                                    else if (b == SUB_PAIRING)
                                    begin
                                        hold_next = HOLD_WANT_MD;
                                    end
                                end
                            end
                            else if (c_vidx == 8'd3)
                            begin
                                if (c_hold == HOLD_WANT_MD)
                                begin
                                    pkind_next  = KIND_PAIRING;
                                    pmodel_next = b;
                                end
                                hold_next = HOLD_NONE;
                            end
                        end
                        else if (c_type == AD_UUID16_INC || c_type == AD_UUID16_ALL)
                        begin
                            if (!c_vidx[0])
                            begin
                                hold_next = b;
                            end
                            else if ((pair == UUID_TRACK_A || pair == UUID_TRACK_B)
                                     && c_pkind == KIND_NONE)
                            begin
                                pkind_next = KIND_UUID;
                            end
                        end
                        vidx_next = c_vidx + 8'd1;
                        if (vidx_next == c_len - 8'd1)
                        begin
                            end_struct = 1'b1;
                        end
                    end
                endcase

                if (end_struct)
                begin
                    if (pkind_next != KIND_NONE && c_fkind == KIND_NONE)
                    begin
                        fkind_next   = pkind_next;
                        fmodel_next  = pmodel_next;
                        stopped_next = 1'b1;
                    end
                    phase_next = PH_LEN;
                end
            end
        end

        r_kind = fkind_next;
        if (fkind_next == KIND_PAIRING)
        begin
            r_model = fmodel_next;
            r_known = is_known_model(fmodel_next);
        end

        out_data_next = {3'd0, r_known, r_model, r_kind, (r_kind != KIND_NONE)};

        if (in_last_reg)
        begin
            count_next   = 8'd0;
            phase_next   = PH_LEN;
            len_next     = 8'd0;
            type_next    = 8'd0;
            vidx_next    = 8'd0;
            hold_next    = HOLD_NONE;
            pkind_next   = KIND_NONE;
            pmodel_next  = 8'd0;
            fkind_next   = KIND_NONE;
            fmodel_next  = 8'd0;
            stopped_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 8'd0;
            phase_reg     <= PH_LEN;
            len_reg       <= 8'd0;
            type_reg      <= 8'd0;
            vidx_reg      <= 8'd0;
            hold_reg      <= HOLD_NONE;
            pkind_reg     <= KIND_NONE;
            pmodel_reg    <= 8'd0;
            fkind_reg     <= KIND_NONE;
            fmodel_reg    <= 8'd0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                count_reg   <= count_next;
                phase_reg   <= phase_next;
                len_reg     <= len_next;
                type_reg    <= type_next;
                vidx_reg    <= vidx_next;
                hold_reg    <= hold_next;
                pkind_reg   <= pkind_next;
                pmodel_reg  <= pmodel_next;
                fkind_reg   <= fkind_next;
                fmodel_reg  <= fmodel_next;
                stopped_reg <= stopped_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_match_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[0] == (out_data_reg[3:1] != KIND_NONE)))
        else $error("matched flag disagrees with kind");

    a_model_only_pairing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3:1] != KIND_PAIRING)
            |-> (out_data_reg[11:4] == 8'd0 && !out_data_reg[12]))
        else $error("model reported for non pairing kind");

    a_found_stops_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (fkind_reg != KIND_NONE) |-> stopped_reg)
        else $error("committed match without stopped walk");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> out_valid_reg)
        else $error("last byte produced no result");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("walk phase out of range");
`endif

endmodule
`default_nettype wire
